@@ hw/rtl/kti_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers of the keyframe track interpolator.
package kti_pkg;

    localparam int MAX_KEYS = 64;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = 7;
    localparam int VAL_W    = 32;
    localparam int TIME_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int NUM_COMP = 4;
    localparam int COMP_W   = 3;

    localparam int IN_TDATA_W  = 200;
    localparam int OUT_TDATA_W = 136;

    localparam int KI_LSB = 0;
    localparam int KT_LSB = 6;
    localparam int VX_LSB = 38;
    localparam int VY_LSB = 70;
    localparam int VZ_LSB = 102;
    localparam int VW_LSB = 134;
    localparam int QT_LSB = 166;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    localparam logic REG_KEY_COUNT   = 1'b0;
    localparam logic REG_INTERP_MODE = 1'b1;

    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_STEP   = 1'b1;

    localparam logic [1:0] STATUS_INTERP = 2'd0;
    localparam logic [1:0] STATUS_FIRST  = 2'd1;
    localparam logic [1:0] STATUS_PAST   = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] t;
        logic [VAL_W-1:0]  w;
        logic [VAL_W-1:0]  z;
        logic [VAL_W-1:0]  y;
        logic [VAL_W-1:0]  x;
    } key_row_t;

    localparam int ROW_W = $bits(key_row_t);

    function automatic logic [VAL_W-1:0] comp_sel(key_row_t row, logic [1:0] c);
        logic [VAL_W-1:0] v;
        case (c)
            2'd0:    v = row.x;
            2'd1:    v = row.y;
            2'd2:    v = row.z;
            default: v = row.w;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/kti_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module kti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/keyframe_track_interpolator.sv @@
`timescale 1ns / 1ps
// Keyframe track interpolator: a keyframe table with linear or step lookup by time.
//
// A write item stores one keyframe and returns nothing. A query item reads the table
// one key per cycle through the table's single read port until it finds the first key
// at or after the query time or reaches the last valid key. In linear mode between two
// keys a restoring divider then makes the 16-bit fraction, and one shared multiplier
// lerps the four components. The block takes no new item while a query is in
// progress, but a finished result waits in the output register without holding up the
// next item.
module keyframe_track_interpolator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [kti_pkg::CNT_W-1:0]           cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // key_index, key_time, value_x, value_y, value_z, value_w, query_time, zero pad
    input  logic [kti_pkg::IN_TDATA_W-1:0]      s_tdata,
    // kind
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_x, out_y, out_z, out_w, key_used, zero pad
    output logic [kti_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // status
    output logic [1:0]                          m_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SEARCH,
        ST_DIVIDE,
        ST_LERP,
        ST_FINISH
    } state_t;

    state_t                              state_reg, state_next;
    logic [kti_pkg::CNT_W-1:0]           key_count_reg;
    logic                                interp_mode_reg;
    logic [kti_pkg::TIME_W-1:0]          q_reg, q_next;
    logic [kti_pkg::IDX_W-1:0]           cmp_idx_reg, cmp_idx_next;
    kti_pkg::key_row_t                   prev_reg, prev_next;
    kti_pkg::key_row_t                   found_reg, found_next;
    logic [1:0]                          status_reg, status_next;
    logic [kti_pkg::TIME_W-1:0]          span_reg, span_next;
    logic [kti_pkg::TIME_W-1:0]          rem_reg, rem_next;
    logic [kti_pkg::FRAC_W-1:0]          quo_reg, quo_next;
    logic [3:0]                          bit_cnt_reg, bit_cnt_next;
    logic [kti_pkg::COMP_W-1:0]          comp_reg, comp_next;
    logic signed [49:0]                  prod_reg, prod_next;
    logic [kti_pkg::VAL_W-1:0]           res_reg [kti_pkg::NUM_COMP];
    logic [kti_pkg::VAL_W-1:0]           res_next [kti_pkg::NUM_COMP];
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [kti_pkg::OUT_TDATA_W-1:0]     m_tdata_reg, m_tdata_next;
    logic [1:0]                          m_tuser_reg, m_tuser_next;

    logic                                in_fire;
    logic                                ram_we;
    logic [kti_pkg::IDX_W-1:0]           ram_waddr;
    kti_pkg::key_row_t                   ram_wrow;
    logic [kti_pkg::IDX_W-1:0]           ram_raddr;
    logic [kti_pkg::ROW_W-1:0]           ram_rdata;
    kti_pkg::key_row_t                   ram_row;
    logic [kti_pkg::IDX_W-1:0]           last_idx;
    logic                                search_hit;
    logic                                search_end;
    logic [32:0]                         rem_sh;
    logic [33:0]                         trial;
    logic [kti_pkg::VAL_W-1:0]           lerp_a;
    logic [kti_pkg::VAL_W-1:0]           lerp_b;
    logic signed [32:0]                  lerp_diff;
    logic signed [49:0]                  prod_full;
    logic [kti_pkg::COMP_W-1:0]          back_idx;
    logic [kti_pkg::VAL_W-1:0]           back_a;
    logic                                out_free;

    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign ram_we    = in_fire && (kti_pkg::kind_t'(s_tuser[0]) == kti_pkg::KIND_WRITE)
                       && (32'(s_tdata[kti_pkg::KI_LSB +: 6]) < 32'(kti_pkg::MAX_KEYS));
    assign ram_waddr = kti_pkg::IDX_W'(s_tdata[kti_pkg::KI_LSB +: 6]);
    assign ram_wrow  = '{t: s_tdata[kti_pkg::KT_LSB +: 32],
                         w: s_tdata[kti_pkg::VW_LSB +: 32],
                         z: s_tdata[kti_pkg::VZ_LSB +: 32],
                         y: s_tdata[kti_pkg::VY_LSB +: 32],
                         x: s_tdata[kti_pkg::VX_LSB +: 32]};
    assign ram_raddr = (state_reg == ST_FETCH) ? '0 : cmp_idx_reg + kti_pkg::IDX_W'(1);
    assign ram_row   = kti_pkg::key_row_t'(ram_rdata);

    kti_ram #(
        .WIDTH (kti_pkg::ROW_W),
        .DEPTH (kti_pkg::MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wrow),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A key count of zero acts as one, and counts above the table size act as the table size.
    always_comb
    begin
        if (key_count_reg == '0)
        begin
            last_idx = '0;
        end
        else if (32'(key_count_reg) > 32'(kti_pkg::MAX_KEYS))
        begin
            last_idx = kti_pkg::IDX_W'(kti_pkg::MAX_KEYS - 1);
        end
        else
        begin
            last_idx = kti_pkg::IDX_W'(key_count_reg - kti_pkg::CNT_W'(1));
        end
    end

    assign search_hit = (ram_row.t >= q_reg);
    assign search_end = (cmp_idx_reg == last_idx);

    assign rem_sh = {rem_reg, 1'b0};
    assign trial  = {1'b0, rem_sh} - {2'b00, span_reg};

    assign lerp_a    = kti_pkg::comp_sel(prev_reg, comp_reg[1:0]);
    assign lerp_b    = kti_pkg::comp_sel(found_reg, comp_reg[1:0]);
    assign lerp_diff = $signed({lerp_b[31], lerp_b}) - $signed({lerp_a[31], lerp_a});
    assign prod_full = lerp_diff * $signed({1'b0, quo_reg});
    assign back_idx  = comp_reg - kti_pkg::COMP_W'(1);
    assign back_a    = kti_pkg::comp_sel(prev_reg, back_idx[1:0]);

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        q_next        = q_reg;
        cmp_idx_next  = cmp_idx_reg;
        prev_next     = prev_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        span_next     = span_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        bit_cnt_next  = bit_cnt_reg;
        comp_next     = comp_reg;
        prod_next     = prod_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (kti_pkg::kind_t'(s_tuser[0]) == kti_pkg::KIND_QUERY))
                begin
                    q_next       = s_tdata[kti_pkg::QT_LSB +: 32];
                    cmp_idx_next = '0;
                    state_next   = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (search_hit || search_end)
                begin
                    found_next = ram_row;
                    for (int i = 0; i < kti_pkg::NUM_COMP; i++)
                    begin
                        res_next[i] = kti_pkg::comp_sel(ram_row, 2'(i));
                    end
                    if (!search_hit)
                    begin
                        status_next = kti_pkg::STATUS_PAST;
                    end
                    else if (cmp_idx_reg == '0)
                    begin
                        status_next = kti_pkg::STATUS_FIRST;
                    end
                    else
                    begin
                        status_next = kti_pkg::STATUS_INTERP;
                    end
                    if (search_hit && (cmp_idx_reg != '0)
                        && (interp_mode_reg == kti_pkg::MODE_LINEAR) && (ram_row.t != q_reg))
                    begin
                        span_next    = ram_row.t - prev_reg.t;
                        rem_next     = q_reg - prev_reg.t;
                        quo_next     = '0;
                        bit_cnt_next = '0;
                        state_next   = ST_DIVIDE;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    prev_next    = ram_row;
                    cmp_idx_next = cmp_idx_reg + kti_pkg::IDX_W'(1);
                end
            end
            ST_DIVIDE:
            begin
                // The remainder stays below the span, so it fits 32 bits after each step.
                if (!trial[33])
                begin
                    rem_next = trial[31:0];
                end
                else
                begin
                    rem_next = rem_sh[31:0];
                end
                quo_next     = {quo_reg[kti_pkg::FRAC_W-2:0], !trial[33]};
                bit_cnt_next = bit_cnt_reg + 4'd1;
                if (bit_cnt_reg == 4'(kti_pkg::FRAC_W - 1))
                begin
                    comp_next  = '0;
                    state_next = ST_LERP;
                end
            end
            ST_LERP:
            begin
                // Multiply one component while the previous product is added.
                if (comp_reg < kti_pkg::COMP_W'(kti_pkg::NUM_COMP))
                begin
                    prod_next = prod_full;
                end
                if (comp_reg != '0)
                begin
                    res_next[back_idx[1:0]] = back_a + prod_reg[47:16];
                end
                comp_next = comp_reg + kti_pkg::COMP_W'(1);
                if (comp_reg == kti_pkg::COMP_W'(kti_pkg::NUM_COMP))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, 6'(cmp_idx_reg),
                                     res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
                    m_tuser_next  = status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            key_count_reg   <= kti_pkg::CNT_W'(1);
            interp_mode_reg <= kti_pkg::MODE_LINEAR;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
            m_tuser_reg     <= '0;
            cmp_idx_reg     <= '0;
            bit_cnt_reg     <= '0;
            comp_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
            cmp_idx_reg  <= cmp_idx_next;
            bit_cnt_reg  <= bit_cnt_next;
            comp_reg     <= comp_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    kti_pkg::REG_KEY_COUNT:   key_count_reg   <= cfg_data;
                    kti_pkg::REG_INTERP_MODE: interp_mode_reg <= cfg_data[0];
                    default:                  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        prev_reg    <= prev_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        span_reg    <= span_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        prod_reg    <= prod_next;
        res_reg     <= res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A new result is only ever loaded from the finishing step of a query.
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == ST_FINISH)
        else $error("result appeared without a finished query");

    // A query answered at or before the first key always reports key zero.
    a_first_key_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == kti_pkg::STATUS_FIRST)) |-> (m_tdata[133:128] == 6'd0))
        else $error("first-key status with nonzero key index");

    // The search never runs past the last valid key.
    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (cmp_idx_reg <= last_idx))
        else $error("search index beyond the last valid key");

    // An accepted query starts its table read in the following cycle.
    a_query_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (s_tuser[0] == kti_pkg::KIND_QUERY)) |=> (state_reg == ST_FETCH))
        else $error("query accepted without starting the search");

endmodule

@@ test/keyframe_track_interpolator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the keyframe track interpolator: table writes and timed lookups.

typedef struct packed {
    logic [1:0]       status;
    logic [5:0]       key_used;
    logic [3:0][31:0] comp;
} lookup_t;

typedef struct packed {
    kti_pkg::kind_t   kind;
    logic [5:0]       idx;
    logic [31:0]      key_time;
    logic [3:0][31:0] value;
    logic [31:0]      query_time;
} track_item_t;

class track_lookup_checker;
    logic [31:0]      key_time_tab [kti_pkg::MAX_KEYS];
    logic [3:0][31:0] key_val_tab  [kti_pkg::MAX_KEYS];
    logic [6:0]       key_count = 7'd1;
    logic             step_mode = kti_pkg::MODE_LINEAR;
    lookup_t          pending_lookups [$];
    int               errors = 0;

    function logic [31:0] lerp(logic [31:0] a, logic [31:0] b, logic [15:0] frac);
        longint base;
        longint prod;
        longint f;
        logic [31:0] r;
        base = longint'($signed(a));
        f = longint'(frac);
        prod = ($signed(b) - base) * f;
        r = 32'(base + (prod >>> 16));
        return r;
    endfunction

    function void note_item(track_item_t it);
        int n;
        int found;
        logic [31:0] span;
        logic [31:0] part;
        logic [47:0] num;
        logic [15:0] frac;
        lookup_t r;
        if (it.kind == kti_pkg::KIND_WRITE)
        begin
            key_time_tab[it.idx] = it.key_time;
            key_val_tab[it.idx] = it.value;
            return;
        end
        n = int'(key_count);
        if (n < 1)
            n = 1;
        if (n > kti_pkg::MAX_KEYS)
            n = kti_pkg::MAX_KEYS;
        found = n;
        for (int i = 0; i < n; i++)
        begin
            if (key_time_tab[i] >= it.query_time)
            begin
                found = i;
                break;
            end
        end
        if (found == n)
        begin
            found = n - 1;
            r.status = kti_pkg::STATUS_PAST;
        end
        else if (found == 0)
            r.status = kti_pkg::STATUS_FIRST;
        else
            r.status = kti_pkg::STATUS_INTERP;
        r.key_used = 6'(found);
        r.comp = key_val_tab[found];
        if (r.status == kti_pkg::STATUS_INTERP && step_mode == kti_pkg::MODE_LINEAR
            && it.query_time != key_time_tab[found])
        begin
            span = key_time_tab[found] - key_time_tab[found - 1];
            part = it.query_time - key_time_tab[found - 1];
            if (span != 0 && part < span)
            begin
                num = {part, 16'h0000};
                num = num / {16'h0000, span};
                frac = num[15:0];
                for (int c = 0; c < kti_pkg::NUM_COMP; c++)
                    r.comp[c] = lerp(key_val_tab[found - 1][c], key_val_tab[found][c], frac);
            end
        end
        pending_lookups.push_back(r);
    endfunction

    function void check_result(logic [kti_pkg::OUT_TDATA_W-1:0] data, logic [1:0] status);
        lookup_t exp_r;
        if (pending_lookups.size() == 0)
        begin
            $display("%0t: result with no query waiting: %h", $time, data);
            errors++;
            return;
        end
        exp_r = pending_lookups.pop_front();
        for (int c = 0; c < kti_pkg::NUM_COMP; c++)
        begin
            if (data[32*c +: 32] !== exp_r.comp[c])
            begin
                $display("%0t: component %0d expected %h actual %h",
                         $time, c, exp_r.comp[c], data[32*c +: 32]);
                errors++;
            end
        end
        if (data[133:128] !== exp_r.key_used)
        begin
            $display("%0t: key_used expected %0d actual %0d",
                     $time, exp_r.key_used, data[133:128]);
            errors++;
        end
        if (status !== exp_r.status)
        begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
            errors++;
        end
    endfunction
endclass

module keyframe_track_interpolator_tb;

    localparam int LIMIT = 500000;
    localparam int QUIET_AFTER = 900;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic                            cfg_index = kti_pkg::REG_KEY_COUNT;
    logic [kti_pkg::CNT_W-1:0]       cfg_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [kti_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]                      s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [kti_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]                      m_tuser;

    track_lookup_checker sb = new();
    int  items_sent = 0;
    int  cycles = 0;
    int  stall_left = 0;
    bit  src_gaps = 1'b1;
    bit  sink_stalls = 1'b1;

    keyframe_track_interpolator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("[keyframe_track_interpolator] ERROR");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (sink_stalls && items_sent < QUIET_AFTER && $urandom_range(0, 3) == 0)
        begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_query(int n);
        int j;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] q;
        j = $urandom_range(0, n - 1);
        lo = sb.key_time_tab[0];
        hi = sb.key_time_tab[n - 1];
        case ($urandom_range(0, 9))
            0: q = $urandom;
            1: q = $urandom_range(0, lo);
            2: q = $urandom_range(hi, 32'hFFFF_FFFF);
            3: q = sb.key_time_tab[j];
            4: q = sb.key_time_tab[j] + 32'd1;
            5: q = sb.key_time_tab[j] - 32'd1;
            default:
            begin
                if (j == 0)
                    q = lo;
                else
                    q = $urandom_range(sb.key_time_tab[j - 1], sb.key_time_tab[j]);
            end
        endcase
        return q;
    endfunction

    task automatic send_item(track_item_t it);
        logic [kti_pkg::IN_TDATA_W-1:0] d;
        d = '0;
        d[kti_pkg::KI_LSB +: kti_pkg::IDX_W] = it.idx;
        d[kti_pkg::KT_LSB +: kti_pkg::TIME_W] = it.key_time;
        d[kti_pkg::VX_LSB +: kti_pkg::VAL_W] = it.value[0];
        d[kti_pkg::VY_LSB +: kti_pkg::VAL_W] = it.value[1];
        d[kti_pkg::VZ_LSB +: kti_pkg::VAL_W] = it.value[2];
        d[kti_pkg::VW_LSB +: kti_pkg::VAL_W] = it.value[3];
        d[kti_pkg::QT_LSB +: kti_pkg::TIME_W] = it.query_time;
        if (src_gaps && items_sent < QUIET_AFTER && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= it.kind;
        do @(posedge clk); while (!s_tready);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic write_key(logic [5:0] idx, logic [31:0] t, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [31:0] w);
        track_item_t it;
        it.kind = kti_pkg::KIND_WRITE;
        it.idx = idx;
        it.key_time = t;
        it.value = {w, z, y, x};
        it.query_time = $urandom;
        send_item(it);
    endtask

    task automatic query(logic [31:0] q);
        track_item_t it;
        it.kind = kti_pkg::KIND_QUERY;
        it.idx = 6'($urandom);
        it.key_time = $urandom;
        it.value = {rand_val(), rand_val(), rand_val(), rand_val()};
        it.query_time = q;
        send_item(it);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_lookups.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [kti_pkg::CNT_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == kti_pkg::REG_KEY_COUNT)
            sb.key_count = val;
        else
            sb.step_mode = val[0];
    endtask

    task automatic set_phase(int kc, logic md);
        drain();
        write_reg(kti_pkg::REG_KEY_COUNT, kti_pkg::CNT_W'(kc));
        write_reg(kti_pkg::REG_INTERP_MODE, kti_pkg::CNT_W'(md));
    endtask

    initial
    begin
        int nk;
        int kc;
        int eff;
        int phase;
        bit noisy;
        logic md;
        longint acc;
        logic [31:0] t;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // With a single valid key every query lands on key 0.
        write_key(0, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        query(32'd0);
        query(32'd100);
        query(32'hFFFF_FFFF);
        write_key(1, 32'd200, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        write_key(2, 32'hFFFF_0000, rand_val(), rand_val(), rand_val(), rand_val());
        set_phase(3, kti_pkg::MODE_LINEAR);
        query(32'd150);
        query(32'd101);
        query(32'd199);
        query(32'd200);
        query(32'hFFFF_0000);
        query(32'hFFFF_FFFF);
        query(32'h1234_5678);
        set_phase(3, kti_pkg::MODE_STEP);
        query(32'd150);
        query(32'd50);
        query(32'hFFFF_FFFF);
        set_phase(0, kti_pkg::MODE_LINEAR);
        query(32'd150);

        // Every entry gets written before any key count above three is used.
        for (int i = 0; i < kti_pkg::MAX_KEYS; i++)
            write_key(6'(i), $urandom, rand_val(), rand_val(), rand_val(), rand_val());

        phase = 0;
        while (items_sent < 1050)
        begin
            nk = ($urandom_range(0, 3) == 0) ? kti_pkg::MAX_KEYS : $urandom_range(2, 16);
            kc = nk;
            case ($urandom_range(0, 7))
                0: kc = 0;
                1: kc = 1;
                2: kc = $urandom_range(65, 127);
                3: kc = kti_pkg::MAX_KEYS;
                default: ;
            endcase
            md = 1'($urandom_range(0, 1));
            if (phase == 0)
            begin
                nk = kti_pkg::MAX_KEYS;
                kc = kti_pkg::MAX_KEYS;
                md = kti_pkg::MODE_LINEAR;
            end
            else if (phase == 1)
            begin
                nk = kti_pkg::MAX_KEYS;
                kc = 127;
                md = kti_pkg::MODE_STEP;
            end
            src_gaps = items_sent <= QUIET_AFTER && $urandom_range(0, 3) != 0;
            sink_stalls = items_sent <= QUIET_AFTER && $urandom_range(0, 3) != 0;
            set_phase(kc, md);

            noisy = $urandom_range(0, 5) == 0;
            case ($urandom_range(0, 3))
                0: acc = 0;
                1: acc = $urandom_range(0, 1000);
                2: acc = $urandom >> 1;
                default: acc = $urandom;
            endcase
            for (int i = 0; i < nk; i++)
            begin
                if (noisy)
                    t = $urandom;
                else
                begin
                    t = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
                    case ($urandom_range(0, 3))
                        0: acc = acc + $urandom_range(0, 2);
                        1: acc = acc + $urandom_range(1, 1000);
                        2: acc = acc + $urandom_range(1, 1 << 20);
                        default: acc = acc + ($urandom >> $urandom_range(6, 12));
                    endcase
                end
                write_key(6'(i), t, rand_val(), rand_val(), rand_val(), rand_val());
            end

            eff = (kc < 1) ? 1 : (kc > kti_pkg::MAX_KEYS) ? kti_pkg::MAX_KEYS : kc;
            repeat ($urandom_range(30, 90)) query(pick_query(eff));
            phase++;
        end

        drain();
        if (sb.errors == 0)
            $display("[keyframe_track_interpolator] OK");
        else
            $display("[keyframe_track_interpolator] ERROR");
        $finish;
    end
endmodule
